// File: rtl/gcds_pkg.sv
// gcds_pkg: shared types and codes for the GUB constraint detect and sort block
// item kind codes, configuration register map and the stored table entry
// no dependencies
`timescale 1ns / 1ps

package gcds_pkg;

	// item kind codes
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_TERM   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// configuration register map (word index from paddr[2])
	localparam logic REG_ENABLE    = 1'b0;
	localparam logic REG_MIN_TERMS = 1'b1;

	// configuration reset values
	localparam logic        ENABLE_RST    = 1'b1;
	localparam logic [15:0] MIN_TERMS_RST = 16'd2;

	// fixed field widths
	localparam int unsigned TERM_W  = 16;
	localparam int unsigned OUT_IDX_W = 16;
	localparam int unsigned TOTAL_W = 6;

	// one stored GUB entry
	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		logic                 value;
		logic [TERM_W-1:0]    terms;
	} gub_entry_t;

endpackage

// File: rtl/gub_constraint_detect_sort.sv
// gub_constraint_detect_sort: classifies constraint headers and terms, stores
// qualifying GUB constraints and emits them sorted by descending term count
// depends on gcds_pkg
`timescale 1ns / 1ps

// Usage:
// Items enter on the item channel (item_valid / item_stall) with fields kind,
// is_equality, term_count, rhs_int, rhs_whole, coef_is_one, var_integer and
// var_fixed. Header and term items are accepted while the block is idle and cause no result.
// An end item judges the open constraint and starts the output phase; the
// block holds item_stall high until the whole run has been delivered.
// Results leave on the result channel (result_valid / result_stall), one per
// stored GUB in stable descending term-count order, last high on the final
// one. A run with no GUB gives one result with gub_valid low.
// Each result is found by one comparator walking the stored table through a
// single registered read port; the whole table is scanned anew for each result.
// A stalled result holds its payload until the transaction completes.
// Reset (arst_n low) clears the run state, sets enable to 1 and min_terms to 2;
// the table needs no clearing. The user writes configuration over the APB port
// only while the block is idle (not enforced): enable at 0x0, min_terms at 0x4.

module gub_constraint_detect_sort
	import gcds_pkg::*;
#(
	parameter int unsigned MAX_GUB    = 32,
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic        is_equality,
	input  logic [15:0] term_count,
	input  logic [15:0] rhs_int,
	input  logic        rhs_whole,
	input  logic        coef_is_one,
	input  logic        var_integer,
	input  logic        var_fixed,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        gub_valid,
	output logic [15:0] constraint_index,
	output logic        instantiation_value,
	output logic [15:0] gub_terms,
	output logic [5:0]  gub_total,
	output logic        overflow,
	output logic        last
);

	localparam int unsigned CW = $clog2(MAX_GUB + 1);
	localparam int unsigned AW = $clog2(MAX_GUB);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]            state_q;

	logic                  enable_q;
	logic [TERM_W-1:0]     min_terms_q;

	logic [INDEX_BITS-1:0] counter_q;
	logic [OUT_IDX_W-1:0]  pend_idx_q;
	logic                  pend_valid_q;
	logic                  pend_ok_q;
	logic [TERM_W-1:0]     pend_terms_q;
	logic                  pend_value_q;
	logic [TERM_W-1:0]     nonfixed_q;
	logic                  ovf_q;
	logic [CW-1:0]         count_q;

	gub_entry_t            mem [MAX_GUB];
	gub_entry_t            rd_data_s1;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_pos_s1;
	logic [CW-1:0]         rd_ptr_q;

	logic [CW-1:0]         emit_q;
	logic                  have_last_q;
	logic [TERM_W-1:0]     last_terms_q;
	logic [AW-1:0]         last_pos_q;
	logic                  best_found_q;
	gub_entry_t            best_q;
	logic [AW-1:0]         best_pos_q;

	logic item_acc, result_acc, cfg_wr;
	logic is_hdr, is_term, is_end;
	logic judge, judge_hit, room, wr_en;
	logic hdr_base_ok, hdr_one, hdr_nm1;
	logic rd_issue, scan_done, eligible, better, final_result;
	gub_entry_t wr_entry;

	// handshakes
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = (state_q == S_EMIT);
	assign result_acc   = result_valid && !result_stall;
	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			min_terms_q <= MIN_TERMS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_MIN_TERMS: min_terms_q <= pwdata[TERM_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration readback
	always_comb begin
		unique case (paddr[2])
			REG_ENABLE:    prdata = {31'd0, enable_q};
			REG_MIN_TERMS: prdata = {16'd0, min_terms_q};
			default:       prdata = 32'd0;
		endcase
	end

	// item decode
	assign is_hdr  = item_acc && (kind == KIND_HEADER);
	assign is_term = item_acc && (kind == KIND_TERM);
	assign is_end  = item_acc && (kind == KIND_END);

	// header classification
	assign hdr_base_ok = is_equality && (term_count >= min_terms_q) && rhs_whole;
	assign hdr_one     = (rhs_int == 16'd1);
	assign hdr_nm1     = (({1'b0, rhs_int} + 17'd1) == {1'b0, term_count});

	// judging of the open constraint on a header or the end item
	assign judge     = is_hdr || is_end;
	assign judge_hit = pend_valid_q && pend_ok_q && enable_q && (nonfixed_q >= min_terms_q);
	assign room      = (count_q < CW'(MAX_GUB));
	assign wr_en     = judge && judge_hit && room;
	assign wr_entry  = '{idx: pend_idx_q, value: pend_value_q, terms: pend_terms_q};

	// scan of the stored table, one entry per cycle
	assign rd_issue  = (state_q == S_SCAN) && (rd_ptr_q < count_q);
	assign scan_done = (state_q == S_SCAN) && !rd_issue && !rd_vld_s1;

	// ordering compare: entry comes after the last emitted one, and before the best so far
	assign eligible = !have_last_q || (last_terms_q > rd_data_s1.terms) ||
		((last_terms_q == rd_data_s1.terms) && (last_pos_q < rd_pos_s1));
	assign better   = !best_found_q || (rd_data_s1.terms > best_q.terms);

	assign final_result = (count_q == '0) || ((emit_q + CW'(1)) == count_q);

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= wr_entry;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
		end
	end

	// run state: pending constraint, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			pend_valid_q <= 1'b0;
			pend_ok_q    <= 1'b0;
			pend_terms_q <= '0;
			pend_value_q <= 1'b0;
			pend_idx_q   <= '0;
			nonfixed_q   <= '0;
			ovf_q        <= 1'b0;
			count_q      <= '0;
		end else if (result_acc && final_result) begin
			counter_q <= '0;
			ovf_q     <= 1'b0;
			count_q   <= '0;
		end else begin
			if (judge && judge_hit) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (is_hdr) begin
				pend_valid_q <= 1'b1;
				pend_idx_q   <= OUT_IDX_W'(counter_q);
				counter_q    <= counter_q + INDEX_BITS'(1);
				pend_terms_q <= term_count;
				pend_ok_q    <= hdr_base_ok && (hdr_one || hdr_nm1);
				pend_value_q <= !hdr_one && hdr_nm1;
				nonfixed_q   <= '0;
			end else if (is_end) begin
				pend_valid_q <= 1'b0;
				pend_ok_q    <= 1'b0;
				pend_terms_q <= '0;
				pend_value_q <= 1'b0;
				nonfixed_q   <= '0;
			end else if (is_term && pend_valid_q) begin
				if (!var_fixed && (nonfixed_q != {TERM_W{1'b1}})) begin
					nonfixed_q <= nonfixed_q + TERM_W'(1);
				end
				if (!coef_is_one || !var_integer) begin
					pend_ok_q <= 1'b0;
				end
			end
		end
	end

	// sequencer for the output phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_ptr_q     <= '0;
			rd_vld_s1    <= 1'b0;
			rd_pos_s1    <= '0;
			emit_q       <= '0;
			have_last_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_pos_s1 <= rd_ptr_q[AW-1:0];
				rd_ptr_q  <= rd_ptr_q + CW'(1);
			end
			if (rd_vld_s1 && eligible && better) begin
				best_found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (is_end) begin
						state_q      <= S_SCAN;
						rd_ptr_q     <= '0;
						emit_q       <= '0;
						have_last_q  <= 1'b0;
						best_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (result_acc) begin
						if (final_result) begin
							state_q <= S_IDLE;
						end else begin
							state_q      <= S_SCAN;
							rd_ptr_q     <= '0;
							emit_q       <= emit_q + CW'(1);
							have_last_q  <= 1'b1;
							best_found_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// best entry of the current scan and the last emitted key
	always_ff @(posedge clk) begin
		if (is_end) begin
			best_q     <= '0;
			best_pos_q <= '0;
		end else if (rd_vld_s1 && eligible && better) begin
			best_q     <= rd_data_s1;
			best_pos_q <= rd_pos_s1;
		end
		if (result_acc) begin
			last_terms_q <= best_q.terms;
			last_pos_q   <= best_pos_q;
		end
	end

	// result payload
	assign gub_valid           = (count_q != '0);
	assign constraint_index    = best_q.idx;
	assign instantiation_value = best_q.value;
	assign gub_terms           = best_q.terms;
	assign gub_total           = TOTAL_W'(count_q);
	assign overflow            = ovf_q;
	assign last                = final_result;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_GUB))
		else $error("stored count exceeds table depth");

	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && kind == KIND_END) |=> item_stall)
		else $error("input not stalled after end transaction");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(result_acc && last) |=> (count_q == '0 && !ovf_q && state_q == S_IDLE))
		else $error("run state not cleared after final result");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("table read data outside scan");

endmodule
